### rtl/sitl_pkg.sv
// Package for the sorted interval table: sizes, codes, request/result types.
// Used by sitl_cmp and the sequencer in rtl/ through scoped names.
package sitl_pkg;

  localparam int unsigned MAX_ENTRIES = 256;
  localparam int unsigned IDX_W       = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned FRAME_W     = 31;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned TAG_W       = 16;
  localparam int unsigned TOTAL_W     = 9;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_DROPPED  = 3'd1,
    ST_FULL     = 3'd2,
    ST_HIT      = 3'd3,
    ST_MISS     = 3'd4,
    ST_CLEARED  = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    DIR_BEFORE = 2'd0,
    DIR_AFTER  = 2'd1,
    DIR_DROP   = 2'd2
  } dir_e;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_CLEAR,
    S_INS_FIRST,
    S_INS_WALK,
    S_PLACE,
    S_SHIFT,
    S_WRITE,
    S_LK_CUR,
    S_LK_NEXT,
    S_LK_PREV
  } state_e;

  typedef struct packed {
    cmd_e                      command;
    logic signed [TIME_W-1:0]  start_time;
    logic signed [TIME_W-1:0]  end_time;
    logic [FRAME_W-1:0]        query_frame;
  } req_t;

  typedef struct packed {
    status_e              status;
    logic [FRAME_W-1:0]   found_start;
    logic [FRAME_W-1:0]   found_end;
    logic [TAG_W-1:0]     entry_tag;
    logic [TOTAL_W-1:0]   entry_total;
  } res_t;

  typedef struct packed {
    logic [FRAME_W-1:0] first;
    logic [FRAME_W-1:0] last;
    logic [TAG_W-1:0]   tag;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // Compare unit verdict plus the possibly trimmed interval.
  typedef struct packed {
    dir_e               dir;
    logic [FRAME_W-1:0] s;
    logic [FRAME_W-1:0] e;
  } cmp_res_t;

endpackage

### rtl/sitl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sitl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/sitl_cmp.sv
// Interval compare/trim unit: places a new interval against one entry.
// Depends on sitl_pkg.
module sitl_cmp (
  input  logic [sitl_pkg::FRAME_W-1:0] s_i,
  input  logic [sitl_pkg::FRAME_W-1:0] e_i,
  input  logic [sitl_pkg::FRAME_W-1:0] first_i,
  input  logic [sitl_pkg::FRAME_W-1:0] last_i,
  output sitl_pkg::cmp_res_t           res_o
);

  always_comb begin
    res_o.dir = sitl_pkg::DIR_DROP;
    res_o.s   = s_i;
    res_o.e   = e_i;
    if (e_i < first_i) begin
      res_o.dir = sitl_pkg::DIR_BEFORE;
    end else if (s_i > last_i) begin
      res_o.dir = sitl_pkg::DIR_AFTER;
    end else if (s_i < first_i && e_i <= last_i) begin
      // overlaps the entry's head: cut back to just before it
      res_o.dir = sitl_pkg::DIR_BEFORE;
      res_o.e   = first_i - 1'b1;
    end else if (e_i > last_i && s_i >= first_i) begin
      res_o.dir = sitl_pkg::DIR_AFTER;
      res_o.s   = last_i + 1'b1;
    end
  end

endmodule

### rtl/sorted_interval_table_insert_lookup.sv
// Sorted interval table: sequencer, table RAM and interval compare unit.
// Depends on sitl_pkg, sitl_ram, sitl_cmp.
//
//   channel   ports              handshake            payload
//   request   start, busy        start && !busy       req_i  (sitl_pkg::req_t)
//   result    done_o             done_o, one cycle    res_o  (sitl_pkg::res_t)
//
// One request at a time; busy stays high until its result has been issued.
// Insert: reads the cursor entry, walks, shifts, then writes the new entry.
// Lookup: reads the cursor entry, then walks. Clear: rewrites entry zero. Bad
// commands and bad intervals are answered from idle. Every step reads one RAM
// entry (one read port). After reset, S_INIT writes entry zero before any request.
// Results cannot be stalled; done_o pulses once per request.
module sorted_interval_table_insert_lookup (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  sitl_pkg::req_t  req_i,
  output logic            done_o,
  output sitl_pkg::res_t  res_o
);

  localparam int unsigned IW = sitl_pkg::IDX_W;
  localparam int unsigned CW = sitl_pkg::CNT_W;
  localparam int unsigned FW = sitl_pkg::FRAME_W;
  localparam int unsigned TW = sitl_pkg::TAG_W;

  sitl_pkg::state_e state_q, state_d;
  logic [CW-1:0]    count_q, count_d;
  logic [IW-1:0]    ins_cur_q, ins_cur_d;
  logic [IW-1:0]    lk_cur_q, lk_cur_d;
  logic [TW-1:0]    tag_q, tag_d;
  logic             done_q, done_d;
  sitl_pkg::res_t   res_q, res_d;

  logic [IW-1:0]    c_q, c_d;
  logic [CW-1:0]    pos_q, pos_d;
  logic             up_q, up_d;
  logic             probe_q, probe_d;
  logic [FW-1:0]    s_q, s_d, e_q, e_d, f_q, f_d;

  logic                         ram_we;
  logic [IW-1:0]                ram_waddr, ram_raddr;
  sitl_pkg::entry_t             ram_wdata, rd;
  logic [sitl_pkg::ENTRY_W-1:0] ram_rdata;
  sitl_pkg::cmp_res_t           cmp;

  logic [IW-1:0]    last_idx;
  logic [CW-1:0]    c_ext;
  logic [CW:0]      c_plus2;
  logic             has_next, has_prev, holds;
  logic             in_bad;

  sitl_ram #(
    .WIDTH (sitl_pkg::ENTRY_W),
    .DEPTH (sitl_pkg::MAX_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd = ram_rdata;

  sitl_cmp u_cmp (
    .s_i     (s_q),
    .e_i     (e_q),
    .first_i (rd.first),
    .last_i  (rd.last),
    .res_o   (cmp)
  );

  function automatic sitl_pkg::res_t mk_res(sitl_pkg::status_e st, logic [FW-1:0] fs,
                                            logic [FW-1:0] fe, logic [TW-1:0] tg);
    sitl_pkg::res_t r;
    r.status      = st;
    r.found_start = fs;
    r.found_end   = fe;
    r.entry_tag   = tg;
    r.entry_total = '0;
    return r;
  endfunction

  assign last_idx = IW'(count_q - 1'b1);
  assign c_ext    = CW'(c_q);
  assign c_plus2  = (CW+1)'(c_q) + 2'd2;
  assign has_next = (c_ext + 1'b1) < count_q;
  assign has_prev = c_q != '0;
  assign holds    = (rd.first <= f_q) && (rd.last >= f_q);
  assign in_bad   = req_i.start_time[sitl_pkg::TIME_W-1] | req_i.end_time[sitl_pkg::TIME_W-1] |
                    (req_i.start_time[FW-1:0] > req_i.end_time[FW-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sitl_pkg::S_INIT;
      count_q   <= CW'(1);
      ins_cur_q <= '0;
      lk_cur_q  <= '0;
      tag_q     <= TW'(1);
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      ins_cur_q <= ins_cur_d;
      lk_cur_q  <= lk_cur_d;
      tag_q     <= tag_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q   <= res_d;
    c_q     <= c_d;
    pos_q   <= pos_d;
    up_q    <= up_d;
    probe_q <= probe_d;
    s_q     <= s_d;
    e_q     <= e_d;
    f_q     <= f_d;
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    ins_cur_d = ins_cur_q;
    lk_cur_d  = lk_cur_q;
    tag_d     = tag_q;
    done_d    = 1'b0;
    res_d     = res_q;
    c_d       = c_q;
    pos_d     = pos_q;
    up_d      = up_q;
    probe_d   = probe_q;
    s_d       = s_q;
    e_d       = e_q;
    f_d       = f_q;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = c_q;

    case (state_q)
      sitl_pkg::S_INIT, sitl_pkg::S_CLEAR: begin
        // entry zero back to [0,0], tag 0
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = '0;
        count_d   = CW'(1);
        ins_cur_d = '0;
        lk_cur_d  = '0;
        tag_d     = TW'(1);
        state_d   = sitl_pkg::S_IDLE;
        if (state_q == sitl_pkg::S_CLEAR) begin
          done_d = 1'b1;
          res_d  = mk_res(sitl_pkg::ST_CLEARED, '0, '0, '0);
        end
      end

      sitl_pkg::S_IDLE: begin
        if (start) begin
          case (req_i.command)
            sitl_pkg::CMD_INSERT: begin
              if (in_bad) begin
                done_d = 1'b1;
                res_d  = mk_res(sitl_pkg::ST_DROPPED, '0, '0, '0);
              end else begin
                s_d       = req_i.start_time[FW-1:0];
                e_d       = req_i.end_time[FW-1:0];
                c_d       = (CW'(ins_cur_q) >= count_q) ? last_idx : ins_cur_q;
                ram_raddr = c_d;
                state_d   = sitl_pkg::S_INS_FIRST;
              end
            end
            sitl_pkg::CMD_LOOKUP: begin
              f_d       = req_i.query_frame;
              c_d       = (CW'(lk_cur_q) >= count_q) ? last_idx : lk_cur_q;
              ram_raddr = c_d;
              state_d   = sitl_pkg::S_LK_CUR;
            end
            sitl_pkg::CMD_CLEAR: begin
              state_d = sitl_pkg::S_CLEAR;
            end
            default: begin
              done_d = 1'b1;
              res_d  = mk_res(sitl_pkg::ST_DROPPED, '0, '0, '0);
            end
          endcase
        end
      end

      sitl_pkg::S_INS_FIRST: begin
        s_d = cmp.s;
        e_d = cmp.e;
        case (cmp.dir)
          sitl_pkg::DIR_AFTER: begin
            up_d  = 1'b1;
            pos_d = count_q;
            if (has_next) begin
              c_d       = c_q + 1'b1;
              ram_raddr = c_d;
              state_d   = sitl_pkg::S_INS_WALK;
            end else begin
              state_d = sitl_pkg::S_PLACE;
            end
          end
          sitl_pkg::DIR_BEFORE: begin
            up_d  = 1'b0;
            pos_d = '0;
            if (has_prev) begin
              c_d       = c_q - 1'b1;
              ram_raddr = c_d;
              state_d   = sitl_pkg::S_INS_WALK;
            end else begin
              state_d = sitl_pkg::S_PLACE;
            end
          end
          default: begin
            // drop on the first compare leaves the cursor alone
            done_d  = 1'b1;
            res_d   = mk_res(sitl_pkg::ST_DROPPED, '0, '0, '0);
            state_d = sitl_pkg::S_IDLE;
          end
        endcase
      end

      sitl_pkg::S_INS_WALK: begin
        s_d = cmp.s;
        e_d = cmp.e;
        case (cmp.dir)
          sitl_pkg::DIR_AFTER: begin
            if (!up_q) begin
              pos_d   = c_ext + 1'b1;
              state_d = sitl_pkg::S_PLACE;
            end else if (has_next) begin
              c_d       = c_q + 1'b1;
              ram_raddr = c_d;
            end else begin
              state_d = sitl_pkg::S_PLACE;
            end
          end
          sitl_pkg::DIR_BEFORE: begin
            if (up_q) begin
              pos_d   = c_ext;
              state_d = sitl_pkg::S_PLACE;
            end else if (has_prev) begin
              c_d       = c_q - 1'b1;
              ram_raddr = c_d;
            end else begin
              state_d = sitl_pkg::S_PLACE;
            end
          end
          default: begin
            ins_cur_d = c_q;
            done_d    = 1'b1;
            res_d     = mk_res(sitl_pkg::ST_DROPPED, '0, '0, '0);
            state_d   = sitl_pkg::S_IDLE;
          end
        endcase
      end

      sitl_pkg::S_PLACE: begin
        if (count_q >= CW'(sitl_pkg::MAX_ENTRIES)) begin
          done_d  = 1'b1;
          res_d   = mk_res(sitl_pkg::ST_FULL, '0, '0, '0);
          state_d = sitl_pkg::S_IDLE;
        end else if (pos_q == count_q) begin
          state_d = sitl_pkg::S_WRITE;
        end else begin
          // c_q becomes the shift destination, starting at the table end
          ram_raddr = last_idx;
          c_d       = IW'(count_q);
          state_d   = sitl_pkg::S_SHIFT;
        end
      end

      sitl_pkg::S_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = c_q;
        ram_wdata = rd;
        if (c_ext > pos_q + 1'b1) begin
          c_d       = c_q - 1'b1;
          ram_raddr = c_q - 1'b1 - 1'b1;
        end else begin
          state_d = sitl_pkg::S_WRITE;
        end
      end

      sitl_pkg::S_WRITE: begin
        ram_we          = 1'b1;
        ram_waddr       = IW'(pos_q);
        ram_wdata.first = s_q;
        ram_wdata.last  = e_q;
        ram_wdata.tag   = tag_q;
        count_d         = count_q + 1'b1;
        if (pos_q <= CW'(lk_cur_q)) begin
          lk_cur_d = lk_cur_q + 1'b1;
        end
        ins_cur_d = IW'(pos_q);
        tag_d     = tag_q + 1'b1;
        done_d    = 1'b1;
        res_d     = mk_res(sitl_pkg::ST_INSERTED, s_q, e_q, tag_q);
        state_d   = sitl_pkg::S_IDLE;
      end

      sitl_pkg::S_LK_CUR: begin
        if (holds) begin
          lk_cur_d = c_q;
          done_d   = 1'b1;
          res_d    = mk_res(sitl_pkg::ST_HIT, rd.first, rd.last, rd.tag);
          state_d  = sitl_pkg::S_IDLE;
        end else if (has_next) begin
          ram_raddr = c_q + 1'b1;
          probe_d   = 1'b1;
          state_d   = sitl_pkg::S_LK_NEXT;
        end else if (has_prev) begin
          ram_raddr = c_q - 1'b1;
          state_d   = sitl_pkg::S_LK_PREV;
        end else begin
          lk_cur_d = c_q;
          done_d   = 1'b1;
          res_d    = mk_res(sitl_pkg::ST_MISS, '0, '0, '0);
          state_d  = sitl_pkg::S_IDLE;
        end
      end

      // rd holds entry c_q + 1
      sitl_pkg::S_LK_NEXT: begin
        if (rd.first <= f_q) begin
          c_d     = c_q + 1'b1;
          probe_d = 1'b0;
          if (rd.last >= f_q) begin
            lk_cur_d = c_q + 1'b1;
            done_d   = 1'b1;
            res_d    = mk_res(sitl_pkg::ST_HIT, rd.first, rd.last, rd.tag);
            state_d  = sitl_pkg::S_IDLE;
          end else if (c_plus2 < (CW+1)'(count_q)) begin
            ram_raddr = c_q + 1'b1 + 1'b1;
          end else begin
            lk_cur_d = c_q + 1'b1;
            done_d   = 1'b1;
            res_d    = mk_res(sitl_pkg::ST_MISS, '0, '0, '0);
            state_d  = sitl_pkg::S_IDLE;
          end
        end else if (probe_q && has_prev) begin
          // upward probe failed on the first step: try the other side
          ram_raddr = c_q - 1'b1;
          state_d   = sitl_pkg::S_LK_PREV;
        end else begin
          lk_cur_d = c_q;
          done_d   = 1'b1;
          res_d    = mk_res(sitl_pkg::ST_MISS, '0, '0, '0);
          state_d  = sitl_pkg::S_IDLE;
        end
      end

      // rd holds entry c_q - 1
      sitl_pkg::S_LK_PREV: begin
        if (rd.last >= f_q) begin
          c_d = c_q - 1'b1;
          if (rd.first <= f_q) begin
            lk_cur_d = c_q - 1'b1;
            done_d   = 1'b1;
            res_d    = mk_res(sitl_pkg::ST_HIT, rd.first, rd.last, rd.tag);
            state_d  = sitl_pkg::S_IDLE;
          end else if (c_q > IW'(1)) begin
            ram_raddr = c_q - 1'b1 - 1'b1;
          end else begin
            lk_cur_d = c_q - 1'b1;
            done_d   = 1'b1;
            res_d    = mk_res(sitl_pkg::ST_MISS, '0, '0, '0);
            state_d  = sitl_pkg::S_IDLE;
          end
        end else begin
          lk_cur_d = c_q;
          done_d   = 1'b1;
          res_d    = mk_res(sitl_pkg::ST_MISS, '0, '0, '0);
          state_d  = sitl_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = sitl_pkg::S_IDLE;
      end
    endcase

    if (done_d) begin
      res_d.entry_total = sitl_pkg::TOTAL_W'(count_d);
    end
  end

  assign busy   = state_q != sitl_pkg::S_IDLE;
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

### tb/sorted_interval_table_checker.sv
// Checker for the sorted interval table: tracks the table contents on its own,
// predicts one result per request and compares it against the result port.
// Depends on sitl_pkg for the request/result types and status codes.
module sorted_interval_table_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  logic           busy,
  input  sitl_pkg::req_t req_i,
  input  logic           done_i,
  input  sitl_pkg::res_t res_i,
  output int             fail_count_o,
  output int             pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import sitl_pkg::*;

  logic [FRAME_W-1:0] span_first [MAX_ENTRIES];
  logic [FRAME_W-1:0] span_last  [MAX_ENTRIES];
  logic [TAG_W-1:0]   span_tag   [MAX_ENTRIES];
  int unsigned        held;
  int unsigned        ins_cur;
  int unsigned        look_cur;
  logic [TAG_W-1:0]   tag_next;

  res_t expected_q [$];
  res_t want;
  int   errs = 0;

  function automatic void table_clear();
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      span_first[i] = '0;
      span_last[i]  = '0;
      span_tag[i]   = '0;
    end
    held     = 1;
    ins_cur  = 0;
    look_cur = 0;
    tag_next = 1;
  endfunction

  // Side of entry k the new interval belongs on; trims s or e on partial overlap.
  function automatic dir_e side_of(int unsigned k, inout logic [31:0] s,
                                   inout logic [31:0] e);
    logic [31:0] a, b;
    a = {1'b0, span_first[k]};
    b = {1'b0, span_last[k]};
    if (e < a) return DIR_BEFORE;
    if (s > b) return DIR_AFTER;
    if (s < a && e <= b) begin
      e = a - 1;
      return DIR_BEFORE;
    end
    if (e > b && s >= a) begin
      s = b + 1;
      return DIR_AFTER;
    end
    return DIR_DROP;
  endfunction

  function automatic bit covers(int unsigned k, logic [FRAME_W-1:0] f);
    return span_first[k] <= f && span_last[k] >= f;
  endfunction

  function automatic int unsigned clamp_idx(int unsigned c);
    return (c >= held) ? held - 1 : c;
  endfunction

  function automatic res_t table_apply(req_t r);
    res_t               o;
    logic [31:0]        s, e;
    logic [FRAME_W-1:0] f;
    int unsigned        c, pos;
    bit                 place, hit;
    dir_e               d;
    o = '0;
    o.status = ST_DROPPED;
    case (r.command)
      CMD_INSERT: begin
        s = r.start_time;
        e = r.end_time;
        if (!(s[31] || e[31] || s > e)) begin
          c = clamp_idx(ins_cur);
          place = 1'b0;
          pos = 0;
          d = side_of(c, s, e);
          if (d == DIR_AFTER) begin
            place = 1'b1;
            pos = held;
            while (c + 1 < held) begin
              c++;
              d = side_of(c, s, e);
              if (d == DIR_DROP) begin
                place = 1'b0;
                ins_cur = c;
                break;
              end
              if (d == DIR_BEFORE) begin
                pos = c;
                break;
              end
            end
          end else if (d == DIR_BEFORE) begin
            place = 1'b1;
            pos = 0;
            while (c > 0) begin
              c--;
              d = side_of(c, s, e);
              if (d == DIR_DROP) begin
                place = 1'b0;
                ins_cur = c;
                break;
              end
              if (d == DIR_AFTER) begin
                pos = c + 1;
                break;
              end
            end
          end
          if (place) begin
            if (held >= MAX_ENTRIES) begin
              o.status = ST_FULL;
            end else begin
              for (int unsigned i = held; i > pos; i--) begin
                span_first[i] = span_first[i-1];
                span_last[i]  = span_last[i-1];
                span_tag[i]   = span_tag[i-1];
              end
              span_first[pos] = s[FRAME_W-1:0];
              span_last[pos]  = e[FRAME_W-1:0];
              span_tag[pos]   = tag_next;
              held++;
              // entries keep identity: lookup cursor follows its entry
              if (pos <= look_cur) look_cur++;
              ins_cur = pos;
              o.status      = ST_INSERTED;
              o.found_start = s[FRAME_W-1:0];
              o.found_end   = e[FRAME_W-1:0];
              o.entry_tag   = tag_next;
              tag_next++;
            end
          end
        end
      end
      CMD_LOOKUP: begin
        f = r.query_frame;
        c = clamp_idx(look_cur);
        hit = covers(c, f);
        if (!hit) begin
          if (c + 1 < held && span_first[c+1] <= f) begin
            while (c + 1 < held && span_first[c+1] <= f) begin
              c++;
              if (covers(c, f)) begin
                hit = 1'b1;
                break;
              end
            end
          end else if (c > 0 && span_last[c-1] >= f) begin
            while (c > 0 && span_last[c-1] >= f) begin
              c--;
              if (covers(c, f)) begin
                hit = 1'b1;
                break;
              end
            end
          end
        end
        look_cur = c;
        if (hit) begin
          o.status      = ST_HIT;
          o.found_start = span_first[c];
          o.found_end   = span_last[c];
          o.entry_tag   = span_tag[c];
        end else begin
          o.status = ST_MISS;
        end
      end
      CMD_CLEAR: begin
        table_clear();
        o.status = ST_CLEARED;
      end
      default: ;
    endcase
    o.entry_total = held[TOTAL_W-1:0];
    return o;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] got);
    if (got !== exp_val) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, got);
      errs++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_clear();
      expected_q.delete();
      pending_o <= 0;
    end else begin
      // compare before taking a new request: a result never belongs to
      // the request accepted at the same edge
      if (done_i === 1'b1) begin
        if (expected_q.size() == 0) begin
          $error("result with no request pending: status %0d", res_i.status);
          errs++;
        end else begin
          want = expected_q.pop_front();
          check_field("status", 32'(want.status), 32'(res_i.status));
          check_field("found_start", 32'(want.found_start), 32'(res_i.found_start));
          check_field("found_end", 32'(want.found_end), 32'(res_i.found_end));
          check_field("entry_tag", 32'(want.entry_tag), 32'(res_i.entry_tag));
          check_field("entry_total", 32'(want.entry_total), 32'(res_i.entry_total));
        end
      end
      if (start === 1'b1 && busy === 1'b0) expected_q.push_back(table_apply(req_i));
      pending_o    <= expected_q.size();
      fail_count_o <= errs;
    end
  end

endmodule

### tb/sorted_interval_table_insert_lookup_test.sv
// Top of the sorted interval table testbench: clock, reset, request stimulus
// and verdict. Depends on sitl_pkg, the block and sorted_interval_table_checker.
module sorted_interval_table_insert_lookup_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sitl_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  localparam int unsigned FRAME_MAX   = 32'h7FFF_FFFF;
  localparam int unsigned WINDOW      = 3000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start;
  logic        busy;
  req_t        req_i;
  logic        done_o;
  res_t        res_o;
  int          fail_count;
  int          pending;
  int unsigned cycles = 0;
  int unsigned idle_pct = 0;
  int unsigned idle_plan [3] = '{0, 63, 13};

  always #10 clk_i = ~clk_i;

  sorted_interval_table_insert_lookup i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  sorted_interval_table_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .req_i        (req_i),
    .done_i       (done_o),
    .res_i        (res_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic req_t noise_req();
    req_t r;
    r.command     = cmd_e'($urandom_range(3));
    r.start_time  = $urandom();
    r.end_time    = $urandom();
    r.query_frame = FRAME_W'($urandom());
    return r;
  endfunction

  function automatic req_t mk(cmd_e c, logic [31:0] s, logic [31:0] e,
                              logic [FRAME_W-1:0] q);
    req_t r;
    r.command     = c;
    r.start_time  = s;
    r.end_time    = e;
    r.query_frame = q;
    return r;
  endfunction

  function automatic req_t rand_insert();
    req_t        r;
    int unsigned s, w;
    r = noise_req();
    r.command = CMD_INSERT;
    case ($urandom_range(19))
      0: ; // full 32-bit values, mostly negative or reversed
      1: begin
        s = $urandom_range(FRAME_MAX);
        r.start_time = s;
        r.end_time   = s + $urandom_range(FRAME_MAX - s);
      end
      2: begin
        s = $urandom_range(WINDOW);
        r.start_time = s + $urandom_range(50, 1);
        r.end_time   = s;
      end
      default: begin
        s = $urandom_range(WINDOW);
        w = ($urandom_range(7) == 0) ? $urandom_range(600) : $urandom_range(60);
        r.start_time = s;
        r.end_time   = s + w;
      end
    endcase
    return r;
  endfunction

  function automatic req_t rand_lookup();
    req_t r;
    r = noise_req();
    r.command = CMD_LOOKUP;
    case ($urandom_range(9))
      0: ;
      1: r.query_frame = FRAME_W'($urandom_range(1) ? FRAME_MAX : 0);
      default: r.query_frame = FRAME_W'($urandom_range(WINDOW + 100));
    endcase
    return r;
  endfunction

  function automatic req_t rand_item();
    req_t        r;
    int unsigned n;
    n = $urandom_range(99);
    r = noise_req();
    if (n < 2) r.command = CMD_UNUSED;
    else if (n < 5) r.command = CMD_CLEAR;
    else if (n < 40) r = rand_lookup();
    else r = rand_insert();
    return r;
  endfunction

  // Present one request and hold it until the block takes it.
  task automatic issue(req_t r);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      start <= 1'b0;
      req_i <= noise_req();
    end
    @(negedge clk_i);
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy !== 1'b0);
  endtask

  initial begin
    rst_ni = 1'b0;
    start  = 1'b0;
    req_i  = '0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    idle_pct = 0;
    issue(mk(CMD_LOOKUP, 0, 0, 0));
    issue(mk(CMD_LOOKUP, 0, 0, FRAME_W'(FRAME_MAX)));
    issue(mk(CMD_INSERT, 32'hFFFF_FFFF, 5, 0));
    issue(mk(CMD_INSERT, 3, 32'h8000_0000, 0));
    issue(mk(CMD_INSERT, 9, 4, 0));
    issue(mk(CMD_INSERT, 10, 20, 0));
    issue(mk(CMD_INSERT, 40, 50, 0));
    issue(mk(CMD_INSERT, 25, 30, 0));
    issue(mk(CMD_INSERT, 15, 35, 0));   // contains an entry
    issue(mk(CMD_INSERT, 26, 28, 0));   // inside an entry
    issue(mk(CMD_INSERT, 25, 30, 0));   // equal to an entry
    issue(mk(CMD_INSERT, 5, 12, 0));    // trimmed at the end, walks back
    issue(mk(CMD_INSERT, 45, 60, 0));   // trimmed at the start
    issue(mk(CMD_INSERT, 32'h7FFF_FFF0, FRAME_MAX, 0));
    issue(mk(CMD_INSERT, 32'h7FFF_FF00, FRAME_MAX, 0));
    issue(mk(CMD_INSERT, FRAME_MAX, FRAME_MAX, 0));
    issue(mk(CMD_INSERT, 32'h8000_0000, 32'h8000_0000, 0));
    issue(mk(CMD_LOOKUP, 0, 0, 27));
    issue(mk(CMD_LOOKUP, 0, 0, 22));
    issue(mk(CMD_LOOKUP, 0, 0, 31'h7FFF_FFF5));
    issue(mk(CMD_LOOKUP, 0, 0, 6));
    issue(mk(CMD_LOOKUP, 0, 0, FRAME_W'(FRAME_MAX)));
    issue(mk(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, FRAME_W'(FRAME_MAX)));
    issue(mk(CMD_CLEAR, 0, 0, 0));
    issue(mk(CMD_LOOKUP, 0, 0, 10));
    issue(mk(CMD_LOOKUP, 0, 0, 0));

    // descending fill: each insert after the first shifts all entries but entry zero, last ones hit full
    idle_pct = 63;
    for (int k = 259; k >= 0; k--) issue(mk(CMD_INSERT, k * 8 + 1, k * 8 + 4, 0));
    repeat (20) begin
      if ($urandom_range(1)) issue(rand_insert());
      else issue(rand_lookup());
    end

    for (int p = 0; p < 3; p++) begin
      idle_pct = idle_plan[p];
      repeat (140) issue(rand_item());
    end

    @(negedge clk_i);
    start <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### sorted_interval_table_insert_lookup.f
rtl/sitl_pkg.sv
rtl/sitl_ram.sv
rtl/sitl_cmp.sv
rtl/sorted_interval_table_insert_lookup.sv
tb/sorted_interval_table_checker.sv
tb/sorted_interval_table_insert_lookup_test.sv
